[src/bfa_pkg.sv]
// Shared types and constants of the bitmap frame allocator.
package bfa_pkg;

  localparam int unsigned NUM_FRAMES_DEF = 65536;
  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned COUNT_W        = 17;
  localparam int unsigned START_W        = 16;
  localparam int unsigned STATUS_W       = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bfa_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_RANGE     = 2'd2
  } bfa_status_e;

  // Window-search operands: p = free windows of the current power-of-two
  // length, r = free windows of the length accumulated so far (by end bit).
  typedef struct packed {
    logic [WORD_BITS-1:0] p;
    logic [WORD_BITS-1:0] r;
  } bfa_win_t;

endpackage

[src/bfa_if.sv]
// Request and response channel interfaces of the bitmap frame allocator.
interface bfa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [bfa_pkg::COUNT_W-1:0]   frame_cnt;
  logic [bfa_pkg::START_W-1:0]   start_frame;

  modport source (output valid, op, frame_cnt, start_frame, input ready);
  modport sink   (input valid, op, frame_cnt, start_frame, output ready);
endinterface

interface bfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bfa_pkg::START_W-1:0]   alloc_frame;
  logic [bfa_pkg::STATUS_W-1:0]  status;

  modport source (output valid, alloc_frame, status, input ready);
  modport sink   (input valid, alloc_frame, status, output ready);
endinterface

[src/bfa_map_mem.sv]
// Occupancy map storage: one write port, one read port with registered data.
module bfa_map_mem #(
  parameter int unsigned  DEPTH = bfa_pkg::NUM_FRAMES_DEF / bfa_pkg::WORD_BITS,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [bfa_pkg::WORD_BITS-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [bfa_pkg::WORD_BITS-1:0] rdata_o
);

  logic [bfa_pkg::WORD_BITS-1:0] mem [DEPTH];
  logic [bfa_pkg::WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/bfa_scan_unit.sv]
// Shared window-search unit: three doubling steps per pass, plus bit counts.
module bfa_scan_unit (
  input  logic              stage_i,
  input  logic [5:0]        cnt_i,
  input  bfa_pkg::bfa_win_t win_i,
  output bfa_pkg::bfa_win_t win_o,
  output logic [6:0]        tail_o,
  output logic [6:0]        lead_o,
  output logic [5:0]        first_o,
  output logic              hit_o
);

  // Pass 0 handles length bits 0..2, pass 1 bits 3..5.
  always_comb begin : doubling
    logic [bfa_pkg::WORD_BITS-1:0] p;
    logic [bfa_pkg::WORD_BITS-1:0] r;
    logic                          empty;
    p     = win_i.p;
    r     = win_i.r;
    empty = stage_i ? (cnt_i[2:0] == 3'd0) : 1'b1;
    for (int j = 0; j < 3; j++) begin
      if (stage_i ? cnt_i[3+j] : cnt_i[j]) begin
        if (empty) begin
          r = p;
        end else begin
          r = (stage_i ? (r << (8 << j)) : (r << (1 << j))) & p;
        end
        empty = 1'b0;
      end
      p = p & (stage_i ? (p << (8 << j)) : (p << (1 << j)));
    end
    win_o.p = p;
    win_o.r = r;
  end

  // Free bits at the bottom and top of the word, lowest window end.
  always_comb begin
    tail_o = 7'd64;
    for (int i = 63; i >= 0; i--) begin
      if (!win_i.p[i]) tail_o = 7'(i);
    end
    lead_o = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (!win_i.p[i]) lead_o = 7'(63 - i);
    end
    first_o = '0;
    for (int i = 63; i >= 0; i--) begin
      if (win_o.r[i]) first_o = 6'(i);
    end
    hit_o = |win_o.r;
  end

endmodule

[src/bitmap_frame_allocator_top.sv]
// Top level of the bitmap first-fit page frame allocator.
// One occupancy bit per page frame (1 = used) lives in an on-chip map of
// NUM_FRAMES/64 words of 64 bits; NUM_FRAMES must be a multiple of 64.
// After reset a clearing pass writes every word to all-used, one word per
// cycle, so the block takes no item until that pass is through. One item is
// worked at a time. Allocate scans the map from frame 1, word by word (one
// map read, then two passes through the shared window unit), and stops
// at the first word that completes a run of frame_cnt free frames; it then
// marks the run used with a read and a write-back of each touched word of
// the map. Free checks bounds and clears the range the same way. A zero
// count or an out-of-range free answers without touching the map.
// The result sits in an output register, so the next item is accepted
// while a result waits; the block only stalls at the end of an item if the
// previous result is still not taken. Frame 0 is never handed out, so
// alloc_frame 0 means no run.
module bitmap_frame_allocator_top #(
  parameter int unsigned NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  bfa_req_if.sink   req,
  bfa_rsp_if.source rsp
);

  localparam int unsigned MAP_WORDS = NUM_FRAMES / bfa_pkg::WORD_BITS;
  localparam int unsigned WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned FRAME_W   = $clog2(NUM_FRAMES);
  localparam int unsigned CHK_W     = (FRAME_W + 1 > 18) ? FRAME_W + 1 : 18;
  localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);

  typedef enum logic [3:0] {
    S_INIT,    // clearing pass
    S_IDLE,
    S_DECODE,
    S_READ,    // scan: read map word
    S_WIN0,    // scan: first window pass
    S_WIN1,    // scan: second pass and decision
    S_SPAN,    // compute last frame of range
    S_UREAD,   // range update: read
    S_UWRITE,  // range update: modify and write back
    S_DONE
  } state_e;

  state_e                      state_q;
  logic [WORD_AW-1:0]          word_q;
  bfa_pkg::bfa_op_e            op_q;
  logic [bfa_pkg::COUNT_W-1:0] count_q;
  logic [bfa_pkg::START_W-1:0] start_q;
  logic [bfa_pkg::COUNT_W-1:0] run_len_q;
  logic [FRAME_W-1:0]          run_start_q;
  logic [FRAME_W-1:0]          range_lo_q;
  logic [FRAME_W-1:0]          range_hi_q;
  logic [6:0]                  tail_q;
  logic [6:0]                  lead_q;
  bfa_pkg::bfa_win_t           win_q;
  logic [bfa_pkg::START_W-1:0] res_frame_q;
  bfa_pkg::bfa_status_e        res_status_q;
  logic [bfa_pkg::START_W-1:0] out_frame_q;
  bfa_pkg::bfa_status_e        out_status_q;
  logic                        out_valid_q;

  // Map port
  logic                          mem_we;
  logic [bfa_pkg::WORD_BITS-1:0] mem_wdata;
  logic                          mem_re;
  logic [bfa_pkg::WORD_BITS-1:0] mem_rdata;

  // Window unit
  logic                          scan_stage;
  bfa_pkg::bfa_win_t             scan_in;
  bfa_pkg::bfa_win_t             scan_out;
  logic [6:0]                    scan_tail;
  logic [6:0]                    scan_lead;
  logic [5:0]                    scan_first;
  logic                          scan_hit;

  logic [bfa_pkg::WORD_BITS-1:0] free_vec;
  logic [FRAME_W-1:0]            base_frame;
  logic [WORD_AW-1:0]            lo_word;
  logic [WORD_AW-1:0]            hi_word;
  logic [17:0]                   carry_sum;
  logic                          carry_hit;
  logic                          inner_hit;
  logic [FRAME_W-1:0]            carry_start;
  logic [FRAME_W-1:0]            inner_start;
  logic [FRAME_W-1:0]            tail_run_start;
  logic                          free_oob;
  logic [FRAME_W-1:0]            span_hi;
  logic [5:0]                    lo_bit;
  logic [5:0]                    hi_bit;
  logic [bfa_pkg::WORD_BITS-1:0] range_mask;

  // Datapath
  always_comb begin
    base_frame = FRAME_W'({word_q, 6'd0});
    lo_word    = WORD_AW'(range_lo_q >> 6);
    hi_word    = WORD_AW'(range_hi_q >> 6);

    // Frame 0 always looks used to the scan.
    free_vec = ~mem_rdata;
    if (word_q == '0) free_vec[0] = 1'b0;

    scan_stage = (state_q == S_WIN1);
    scan_in    = scan_stage ? win_q : bfa_pkg::bfa_win_t'{p: free_vec, r: '1};

    // Run carried in from lower words, extended by this word's low free bits.
    carry_sum   = 18'(run_len_q) + 18'(tail_q);
    carry_hit   = (carry_sum >= 18'(count_q));
    carry_start = (run_len_q == '0) ? base_frame : run_start_q;

    // Run wholly inside this word; window end bit minus length plus one.
    inner_hit   = scan_hit && (count_q < bfa_pkg::COUNT_W'(64));
    inner_start = FRAME_W'({word_q, 6'(scan_first - count_q[5:0] + 6'd1)});

    tail_run_start = FRAME_W'({word_q, 6'(7'd64 - lead_q)});

    free_oob = (CHK_W'(start_q) + CHK_W'(count_q)) > CHK_W'(NUM_FRAMES);
    span_hi  = FRAME_W'(CHK_W'(range_lo_q) + CHK_W'(count_q) - CHK_W'(1));

    lo_bit     = (word_q == lo_word) ? range_lo_q[5:0] : 6'd0;
    hi_bit     = (word_q == hi_word) ? range_hi_q[5:0] : 6'd63;
    range_mask = ({bfa_pkg::WORD_BITS{1'b1}} << lo_bit)
               & ({bfa_pkg::WORD_BITS{1'b1}} >> (6'd63 - hi_bit));

    mem_re = (state_q == S_READ) || (state_q == S_UREAD);
    mem_we = (state_q == S_INIT) || (state_q == S_UWRITE);
    if (state_q == S_INIT) begin
      mem_wdata = '1;
    end else if (op_q == bfa_pkg::OP_ALLOC) begin
      mem_wdata = mem_rdata | range_mask;
    end else begin
      mem_wdata = mem_rdata & ~range_mask;
    end
  end

  bfa_map_mem #(
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (word_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (word_q),
    .rdata_o (mem_rdata)
  );

  bfa_scan_unit u_scan (
    .stage_i (scan_stage),
    .cnt_i   (count_q[5:0]),
    .win_i   (scan_in),
    .win_o   (scan_out),
    .tail_o  (scan_tail),
    .lead_o  (scan_lead),
    .first_o (scan_first),
    .hit_o   (scan_hit)
  );

  // Window operands between the two passes; payload only.
  always_ff @(posedge clk_i) begin
    if (state_q == S_WIN0) begin
      win_q <= scan_out;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      word_q       <= '0;
      op_q         <= bfa_pkg::OP_ALLOC;
      count_q      <= '0;
      start_q      <= '0;
      run_len_q    <= '0;
      run_start_q  <= '0;
      range_lo_q   <= '0;
      range_hi_q   <= '0;
      tail_q       <= '0;
      lead_q       <= '0;
      res_frame_q  <= '0;
      res_status_q <= bfa_pkg::STATUS_OK;
      out_frame_q  <= '0;
      out_status_q <= bfa_pkg::STATUS_OK;
      out_valid_q  <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid_q && rsp.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          if (word_q == LAST_WORD) begin
            word_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            word_q <= word_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op_q    <= bfa_pkg::bfa_op_e'(req.op);
            count_q <= req.frame_cnt;
            start_q <= req.start_frame;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_frame_q <= '0;
          if (op_q == bfa_pkg::OP_ALLOC) begin
            if (count_q == '0) begin
              res_status_q <= bfa_pkg::STATUS_NOT_FOUND;
              state_q      <= S_DONE;
            end else begin
              word_q      <= '0;
              run_len_q   <= '0;
              run_start_q <= '0;
              state_q     <= S_READ;
            end
          end else if (free_oob) begin
            res_status_q <= bfa_pkg::STATUS_RANGE;
            state_q      <= S_DONE;
          end else if (count_q == '0) begin
            res_status_q <= bfa_pkg::STATUS_OK;
            state_q      <= S_DONE;
          end else begin
            range_lo_q   <= FRAME_W'(start_q);
            res_status_q <= bfa_pkg::STATUS_OK;
            state_q      <= S_SPAN;
          end
        end
        S_READ: begin
          state_q <= S_WIN0;
        end
        S_WIN0: begin
          tail_q  <= scan_tail;
          lead_q  <= scan_lead;
          state_q <= S_WIN1;
        end
        S_WIN1: begin
          if (carry_hit) begin
            range_lo_q   <= carry_start;
            res_frame_q  <= bfa_pkg::START_W'(carry_start);
            res_status_q <= bfa_pkg::STATUS_OK;
            state_q      <= S_SPAN;
          end else if (inner_hit) begin
            range_lo_q   <= inner_start;
            res_frame_q  <= bfa_pkg::START_W'(inner_start);
            res_status_q <= bfa_pkg::STATUS_OK;
            state_q      <= S_SPAN;
          end else begin
            if (tail_q == 7'd64) begin
              // whole word free: run keeps growing
              run_len_q <= run_len_q + bfa_pkg::COUNT_W'(64);
              if (run_len_q == '0) run_start_q <= base_frame;
            end else begin
              run_len_q   <= bfa_pkg::COUNT_W'(lead_q);
              run_start_q <= tail_run_start;
            end
            if (word_q == LAST_WORD) begin
              res_frame_q  <= '0;
              res_status_q <= bfa_pkg::STATUS_NOT_FOUND;
              state_q      <= S_DONE;
            end else begin
              word_q  <= word_q + 1'b1;
              state_q <= S_READ;
            end
          end
        end
        S_SPAN: begin
          range_hi_q <= span_hi;
          word_q     <= lo_word;
          state_q    <= S_UREAD;
        end
        S_UREAD: begin
          state_q <= S_UWRITE;
        end
        S_UWRITE: begin
          if (word_q == hi_word) begin
            state_q <= S_DONE;
          end else begin
            word_q  <= word_q + 1'b1;
            state_q <= S_UREAD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || rsp.ready) begin
            out_valid_q  <= 1'b1;
            out_frame_q  <= res_frame_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_INIT;
        end
      endcase
    end
  end

  assign req.ready       = (state_q == S_IDLE);
  assign rsp.valid       = out_valid_q;
  assign rsp.alloc_frame = out_frame_q;
  assign rsp.status      = out_status_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> !req.ready)
    else $error("allocator ready right after accepting an item");

  a_fail_zero_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && (rsp.status != 2'(bfa_pkg::STATUS_OK)) |-> rsp.alloc_frame == '0)
    else $error("failed request returned a nonzero frame");

  a_run_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WIN1) |-> (run_len_q < count_q))
    else $error("carried run reached count without a hit");

  a_word_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_q <= LAST_WORD)
    else $error("word index beyond map");

  a_update_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UWRITE) |-> (word_q >= lo_word) && (word_q <= hi_word))
    else $error("range update outside its words");
`endif

endmodule
